// ===== hdl/wcds_pkg.sv =====
// Package for the weighted channel dwell scheduler.
// Shared constants: defaults, register indexes, function codes and field widths.
// No dependencies.
package wcds_pkg;
	localparam int CHANNELS_DEF       = 11;
	localparam int PERIOD_RESET       = 1100;
	localparam int MIN_INTERVAL_RESET = 100;
	localparam int EARLY_SLACK_MS     = 5;

	localparam int PERIOD_W = 20;
	localparam int MIN_W    = 16;
	localparam int CHAN_W   = 5;
	localparam int TIME_W   = 32;
	localparam int COUNT_W  = 32;
	localparam int RATE_W   = 48;
	localparam int SUM_W    = 52;
	localparam int PROD_W   = RATE_W + PERIOD_W;

	// configuration register indexes
	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_MIN    = 1'b1;

	// input function codes
	localparam logic FUNC_PACKET = 1'b0;
	localparam logic FUNC_TIMER  = 1'b1;
endpackage

// ===== hdl/weighted_channel_dwell_scheduler.sv =====
// Weighted channel dwell scheduler, top level.
// Depends on wcds_pkg.
// A packet transfer credits a channel count. A timer transfer gives the next
// channel and its interval in the cycle after, except after the last channel of
// a rotation: then the intervals are recomputed through one shared restoring
// divider and one shift-add multiplier, first the rates and then the shares,
// during which in_ready is low.
module weighted_channel_dwell_scheduler #(
	parameter int CHANNELS = wcds_pkg::CHANNELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [wcds_pkg::PERIOD_W-1:0] cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [wcds_pkg::TIME_W-1:0]   time_ms,
	input  logic                          has_tag,
	input  logic [7:0]                    tx_channel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [wcds_pkg::CHAN_W-1:0]   channel,
	output logic [wcds_pkg::PERIOD_W-1:0] dwell_ms
);
	localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW = wcds_pkg::PERIOD_W;
	localparam int CW = wcds_pkg::CHAN_W;
	localparam int TW = wcds_pkg::TIME_W;
	localparam int NW = wcds_pkg::COUNT_W;
	localparam int RW = wcds_pkg::RATE_W;
	localparam int SW = wcds_pkg::SUM_W;
	localparam int DW = wcds_pkg::PROD_W;
	localparam logic [PW-1:0] RST_IVAL = PW'(wcds_pkg::PERIOD_RESET / CHANNELS);
	localparam logic [TW-1:0] RST_MEAS = TW'(wcds_pkg::PERIOD_RESET / CHANNELS);
	localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);
	localparam logic [CW-1:0] LAST_CH  = CW'(CHANNELS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RATE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_RDONE = 4'd3;
	localparam logic [3:0] S_CHK   = 4'd4;
	localparam logic [3:0] S_FIND  = 4'd5;
	localparam logic [3:0] S_MSET  = 4'd6;
	localparam logic [3:0] S_MUL   = 4'd7;
	localparam logic [3:0] S_APPLY = 4'd8;
	localparam logic [3:0] S_CLEAR = 4'd9;

	logic [3:0]          st_q;
	logic [PW-1:0]       period_q;
	logic [15:0]         min_q;
	logic [CW-1:0]       cur_q;
	logic [TW-1:0]       start_q;
	logic [NW-1:0]       counts_q [CHANNELS];
	logic [PW-1:0]       ival_q   [CHANNELS];
	logic [TW-1:0]       meas_q   [CHANNELS];
	logic [RW-1:0]       rate_q   [CHANNELS];
	logic [CHANNELS-1:0] done_q;
	logic [IW-1:0]       idx_q;
	logic [IW-1:0]       best_q;
	logic [RW-1:0]       best_rate_q;
	logic                bv_q;
	logic [SW-1:0]       sum_q;
	logic [PW-1:0]       tl_q;
	logic                share_q;
	logic [6:0]          cnt_q;
	logic [DW-1:0]       dvd_q;
	logic [SW-1:0]       dvs_q;
	logic [SW-1:0]       rem_q;
	logic [RW-1:0]       quo_q;
	logic [DW-1:0]       acc_q;
	logic                out_valid_q;
	logic [CW-1:0]       out_chan_q;
	logic [PW-1:0]       out_dwell_q;

	// packet credit target
	logic [TW-1:0] diff;
	logic          pk_cur;
	logic          pk_ok;
	logic [CW-1:0] tgt;
	logic [IW-1:0] cnt_addr;
	logic [NW-1:0] cnt_rd;
	logic [IW-1:0] ival_addr;
	logic [PW-1:0] ival_rd;
	logic          accept;

	assign accept = in_valid && in_ready;
	assign diff   = time_ms - start_q + TW'(wcds_pkg::EARLY_SLACK_MS);
	assign pk_cur = !diff[TW-1];
	assign tgt    = pk_cur ? cur_q : cur_q - CW'(1);
	assign pk_ok  = has_tag && (cur_q != '0) && (pk_cur || cur_q != CW'(1))
		&& (tx_channel == 8'h00 || tx_channel == {3'b000, tgt});

	// single read address per array
	always_comb begin
		logic [CW-1:0] t1;
		t1       = tgt - CW'(1);
		cnt_addr = (st_q == S_IDLE) ? t1[IW-1:0] : idx_q;
		cnt_rd   = counts_q[cnt_addr];
		ival_addr = (st_q == S_IDLE) ? cur_q[IW-1:0] : '0;
		ival_rd   = ival_q[ival_addr];
	end

	// shared divider step
	logic [SW:0]   r2;
	logic          ge;
	logic [SW-1:0] rem_n;
	logic [RW-1:0] quo_n;
	assign r2    = {rem_q, dvd_q[DW-1]};
	assign ge    = r2 >= {1'b0, dvs_q};
	assign rem_n = ge ? SW'(r2 - {1'b0, dvs_q}) : rem_q << 1 | SW'(dvd_q[DW-1]);
	assign quo_n = {quo_q[RW-2:0], ge};

	// shift-add multiplier step
	logic [DW-1:0] acc_n;
	assign acc_n = (acc_q << 1) + (tl_q[cnt_q[4:0]] ? DW'(best_rate_q) : '0);

	// minimum search candidate
	logic take;
	assign take = !done_q[idx_q] && (!bv_q || rate_q[idx_q] < best_rate_q);

	// share to interval
	logic [PW-1:0] q20;
	logic [PW-1:0] ivl;
	assign q20 = quo_q[PW-1:0];
	assign ivl = (q20 < PW'(min_q)) ? PW'(min_q) : q20;

	assign in_ready  = (st_q == S_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign channel   = out_chan_q;
	assign dwell_ms  = out_dwell_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PW'(wcds_pkg::PERIOD_RESET);
			min_q    <= 16'(wcds_pkg::MIN_INTERVAL_RESET);
		end else if (cfg_we) begin
			case (cfg_idx)
				wcds_pkg::REG_PERIOD: period_q <= cfg_wdata;
				wcds_pkg::REG_MIN:    min_q    <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// sequencer and state arrays
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cur_q       <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
			done_q      <= '0;
			idx_q       <= '0;
			best_q      <= '0;
			bv_q        <= 1'b0;
			sum_q       <= '0;
			tl_q        <= '0;
			share_q     <= 1'b0;
			cnt_q       <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				counts_q[i] <= '0;
				ival_q[i]   <= RST_IVAL;
				meas_q[i]   <= RST_MEAS;
				rate_q[i]   <= '0;
			end
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (accept && func == wcds_pkg::FUNC_PACKET) begin
						if (pk_ok && cnt_rd != '1)
							counts_q[cnt_addr] <= cnt_rd + NW'(1);
					end else if (accept) begin
						if (cur_q != '0)
							meas_q[IW'(cur_q - CW'(1))] <= time_ms - start_q;
						start_q <= time_ms;
						if (cur_q == LAST_CH) begin
							idx_q <= '0;
							sum_q <= '0;
							st_q  <= S_RATE;
						end else begin
							cur_q       <= cur_q + CW'(1);
							out_valid_q <= 1'b1;
							out_chan_q  <= cur_q + CW'(1);
							out_dwell_q <= ival_rd;
						end
					end
				end
				// start rate division for one channel
				S_RATE: begin
					if (meas_q[idx_q] == '0) begin
						quo_q <= '0;
						st_q  <= S_RDONE;
					end else begin
						dvd_q   <= DW'({cnt_rd, 16'h0000});
						dvs_q   <= SW'(meas_q[idx_q]);
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= 7'(DW - 1);
						share_q <= 1'b0;
						st_q    <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_n;
					quo_q <= quo_n;
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0)
						st_q <= share_q ? S_APPLY : S_RDONE;
				end
				S_RDONE: begin
					rate_q[idx_q] <= quo_q;
					sum_q         <= sum_q + SW'(quo_q);
					if (idx_q == LAST_IDX) begin
						st_q <= S_CHK;
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q  <= S_RATE;
					end
				end
				S_CHK: begin
					idx_q  <= '0;
					bv_q   <= 1'b0;
					done_q <= '0;
					tl_q   <= period_q;
					st_q   <= (sum_q == '0) ? S_CLEAR : S_FIND;
				end
				// scan for lowest rate not yet placed
				S_FIND: begin
					if (take) begin
						best_q      <= idx_q;
						best_rate_q <= rate_q[idx_q];
						bv_q        <= 1'b1;
					end
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						st_q  <= (bv_q || take) ? S_MSET : S_CLEAR;
					end else begin
						idx_q <= idx_q + IW'(1);
					end
				end
				S_MSET: begin
					if (sum_q == '0) begin
						quo_q <= '0;
						st_q  <= S_APPLY;
					end else begin
						acc_q <= '0;
						cnt_q <= 7'(PW - 1);
						st_q  <= S_MUL;
					end
				end
				S_MUL: begin
					acc_q <= acc_n;
					cnt_q <= cnt_q - 7'd1;
					if (cnt_q == '0) begin
						dvd_q   <= acc_n;
						dvs_q   <= sum_q;
						rem_q   <= '0;
						quo_q   <= '0;
						cnt_q   <= 7'(DW - 1);
						share_q <= 1'b1;
						st_q    <= S_DIV;
					end
				end
				S_APPLY: begin
					ival_q[best_q] <= ivl;
					tl_q           <= (tl_q > ivl) ? tl_q - ivl : '0;
					sum_q          <= sum_q - SW'(best_rate_q);
					done_q[best_q] <= 1'b1;
					bv_q           <= 1'b0;
					idx_q          <= '0;
					st_q           <= S_FIND;
				end
				S_CLEAR: begin
					for (int i = 0; i < CHANNELS; i++)
						counts_q[i] <= '0;
					cur_q       <= CW'(1);
					out_valid_q <= 1'b1;
					out_chan_q  <= CW'(1);
					out_dwell_q <= ival_rd;
					st_q        <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/wcds_chk.sv =====
// Port-level checker for the weighted channel dwell scheduler, with bind.
// Depends on wcds_pkg and the top level's ports.
module wcds_chk #(
	parameter int CHANNELS = wcds_pkg::CHANNELS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          func,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [wcds_pkg::CHAN_W-1:0]   channel,
	input logic [wcds_pkg::PERIOD_W-1:0] dwell_ms
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(dwell_ms))
		else $error("stalled result changed");

	// shown channel is in range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> channel >= 1 && channel <= wcds_pkg::CHAN_W'(CHANNELS))
		else $error("channel out of range");

	// a timer transfer gives a result next cycle or starts a recompute
	a_timer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == wcds_pkg::FUNC_TIMER |=> out_valid || !in_ready)
		else $error("timer transfer lost");

	// a packet transfer never makes a result
	a_packet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && func == wcds_pkg::FUNC_PACKET && !out_valid |=> !out_valid)
		else $error("packet transfer made a result");
endmodule

bind weighted_channel_dwell_scheduler wcds_chk #(.CHANNELS(CHANNELS)) u_wcds_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready), .func(func),
	.out_valid(out_valid), .out_ready(out_ready), .channel(channel), .dwell_ms(dwell_ms)
);

// ===== sim/weighted_channel_dwell_scheduler_tb.sv =====
// Testbench for the weighted channel dwell scheduler.
// Checks every channel/interval result against a predictor kept in a scoreboard class.
// Depends on wcds_pkg and the weighted_channel_dwell_scheduler RTL.
module weighted_channel_dwell_scheduler_tb;
	localparam int CH         = wcds_pkg::CHANNELS_DEF;
	localparam int IDLE_LIMIT = 40000;
	localparam int SETTLE     = 50;

	typedef struct packed {
		logic [wcds_pkg::CHAN_W-1:0]   chan;
		logic [wcds_pkg::PERIOD_W-1:0] dwell;
	} hop_t;

	// predicts the next hop and holds the hops still to be seen
	class hop_scoreboard;
		logic [wcds_pkg::PERIOD_W-1:0] period;
		logic [wcds_pkg::MIN_W-1:0]    min_ival;
		int unsigned                   cur;
		logic [wcds_pkg::TIME_W-1:0]   start;
		logic [wcds_pkg::COUNT_W-1:0]  counts[CH];
		logic [wcds_pkg::PERIOD_W-1:0] ivals[CH];
		logic [wcds_pkg::TIME_W-1:0]   meas[CH];
		hop_t                          pending[$];
		int                            errors;

		function new();
			period   = wcds_pkg::PERIOD_W'(wcds_pkg::PERIOD_RESET);
			min_ival = wcds_pkg::MIN_W'(wcds_pkg::MIN_INTERVAL_RESET);
			cur      = 0;
			start    = '0;
			errors   = 0;
			for (int i = 0; i < CH; i++) begin
				counts[i] = '0;
				ivals[i]  = wcds_pkg::PERIOD_W'(wcds_pkg::PERIOD_RESET / CH);
				meas[i]   = wcds_pkg::TIME_W'(wcds_pkg::PERIOD_RESET / CH);
			end
		endfunction

		function void write_reg(logic idx, logic [wcds_pkg::PERIOD_W-1:0] data);
			if (idx == wcds_pkg::REG_PERIOD) period = data;
			else min_ival = data[wcds_pkg::MIN_W-1:0];
		endfunction

		// share out the period by capture rate, lowest rate first
		function void reshare();
			logic [wcds_pkg::RATE_W-1:0] rate[CH];
			logic [wcds_pkg::SUM_W-1:0]  sum;
			logic [63:0]                 remain_ms;
			logic [127:0]                share;
			logic [127:0]                ival;
			bit                          done[CH];
			int                          best;
			sum = '0;
			for (int i = 0; i < CH; i++) begin
				rate[i] = (meas[i] == 0) ? '0 : ({16'b0, counts[i], 16'b0} / meas[i]);
				sum += rate[i];
				done[i] = 0;
			end
			if (sum == 0) return;
			remain_ms = 64'(period);
			for (int n = 0; n < CH; n++) begin
				best = -1;
				for (int i = 0; i < CH; i++)
					if (!done[i] && (best < 0 || rate[i] < rate[best])) best = i;
				done[best] = 1;
				share = (sum == 0) ? '0 : (128'(rate[best]) * 128'(remain_ms)) / 128'(sum);
				ival = (share < min_ival) ? 128'(min_ival) : share;
				ivals[best] = ival[wcds_pkg::PERIOD_W-1:0];
				remain_ms = (128'(remain_ms) > ival) ? remain_ms - ival[63:0] : '0;
				sum -= rate[best];
			end
		endfunction

		// an accepted input transfer
		function void note_input(logic fn, logic [wcds_pkg::TIME_W-1:0] t, logic tag,
				logic [7:0] tx);
			logic [wcds_pkg::TIME_W-1:0] rel;
			int unsigned                 target;
			hop_t                        hop;
			if (fn == wcds_pkg::FUNC_PACKET) begin
				if (!tag || cur == 0) return;
				rel = t - start + wcds_pkg::TIME_W'(wcds_pkg::EARLY_SLACK_MS);
				if (!rel[wcds_pkg::TIME_W-1]) target = cur;
				else if (cur == 1) return;
				else target = cur - 1;
				if ((tx == 0 || tx == target) && counts[target-1] != '1)
					counts[target-1]++;
				return;
			end
			if (cur > 0) meas[cur-1] = t - start;
			if (cur >= CH) begin
				reshare();
				cur = 0;
				for (int i = 0; i < CH; i++) counts[i] = '0;
			end
			cur++;
			hop.chan  = wcds_pkg::CHAN_W'(cur);
			hop.dwell = ivals[cur-1];
			pending.insert(pending.size(), hop);
			start = t;
		endfunction

		// an accepted result transfer
		function void check_hop(logic [wcds_pkg::CHAN_W-1:0] c,
				logic [wcds_pkg::PERIOD_W-1:0] d);
			hop_t exp_hop;
			if (pending.size() == 0) begin
				$error("unexpected result: channel %0d dwell_ms %0d", c, d);
				errors++;
				return;
			end
			exp_hop = pending.pop_front();
			if (c !== exp_hop.chan) begin
				$error("channel: expected %0d, actual %0d", exp_hop.chan, c);
				errors++;
			end
			if (d !== exp_hop.dwell) begin
				$error("dwell_ms: expected %0d, actual %0d", exp_hop.dwell, d);
				errors++;
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_idx;
	logic [wcds_pkg::PERIOD_W-1:0] cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic                          func;
	logic [wcds_pkg::TIME_W-1:0]   time_ms;
	logic                          has_tag;
	logic [7:0]                    tx_channel;
	logic                          out_valid;
	logic                          out_ready;
	logic [wcds_pkg::CHAN_W-1:0]   channel;
	logic [wcds_pkg::PERIOD_W-1:0] dwell_ms;

	hop_scoreboard               sb;
	logic [wcds_pkg::TIME_W-1:0] now;
	int                          idle_cycles;
	int                          out_stall;
	bit                          out_calm;

	weighted_channel_dwell_scheduler DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.time_ms    (time_ms),
		.has_tag    (has_tag),
		.tx_channel (tx_channel),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.channel    (channel),
		.dwell_ms   (dwell_ms)
	);

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// one input transfer; returns at the edge where it is accepted
	task automatic send(logic fn, logic [wcds_pkg::TIME_W-1:0] t, logic tag, logic [7:0] tx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		func       <= fn;
		time_ms    <= t;
		has_tag    <= tag;
		tx_channel <= tx;
		do @(posedge clk); while (!in_ready);
		sb.note_input(fn, t, tag, tx);
	endtask

	// register write once all hops are out and the block has settled
	task automatic write_reg(logic idx, logic [wcds_pkg::PERIOD_W-1:0] data);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
	endtask

	// one dwell on the current channel: packets around it, some sent as timers, then the timer
	task automatic dwell_round();
		int                          npkt;
		int                          r;
		logic [wcds_pkg::TIME_W-1:0] span;
		logic [wcds_pkg::TIME_W-1:0] t;
		logic [7:0]                  tx;
		r = $urandom_range(0, 99);
		if (r < 5) span = 0;
		else if (r < 90) span = $urandom_range(1, 200);
		else span = $urandom;
		npkt = $urandom_range(0, 8);
		for (int k = 0; k < npkt; k++) begin
			t = now + $urandom_range(0, (span > 300) ? 300 : span) - $urandom_range(0, 12);
			r = $urandom_range(0, 99);
			if (r < 50) tx = 8'd0;
			else if (r < 80) tx = 8'(sb.cur);
			else if (r < 90 && sb.cur > 1) tx = 8'(sb.cur - 1);
			else tx = 8'($urandom_range(0, 255));
			send(($urandom_range(0, 19) == 0) ? wcds_pkg::FUNC_TIMER : wcds_pkg::FUNC_PACKET,
				t, ($urandom_range(0, 9) != 0), tx);
		end
		now = now + span;
		send(wcds_pkg::FUNC_TIMER, now, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endtask

	// result side: random stalls, with calm stretches
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_stall <= 0;
			out_calm  <= 1'b0;
		end else begin
			if (out_valid && out_ready) sb.check_hop(channel, dwell_ms);
			if ($urandom_range(0, 199) == 0) out_calm <= ~out_calm;
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				out_stall <= out_stall - 1;
			end else begin
				out_ready <= 1'b1;
				if (!out_calm) out_stall <= pick_gap();
			end
		end
	end

	// watchdog on cycles with no transfer at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// stimulus
	initial begin
		sb          = new();
		idle_cycles = 0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_idx     = wcds_pkg::REG_PERIOD;
		cfg_wdata   = '0;
		in_valid    = 1'b0;
		func        = wcds_pkg::FUNC_PACKET;
		time_ms     = '0;
		has_tag     = 1'b0;
		tx_channel  = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: no channel yet, early packet on first channel, tag and match rules
		now = 32'hFFFF_FF00;
		send(wcds_pkg::FUNC_PACKET, now, 1'b1, 8'd0);
		send(wcds_pkg::FUNC_TIMER, now, 1'b0, 8'd0);
		send(wcds_pkg::FUNC_PACKET, now + 1, 1'b0, 8'd0);
		send(wcds_pkg::FUNC_PACKET, now - 10, 1'b1, 8'd0);
		send(wcds_pkg::FUNC_PACKET, now + 3, 1'b1, 8'd1);
		send(wcds_pkg::FUNC_PACKET, now + 4, 1'b1, 8'd2);
		send(wcds_pkg::FUNC_PACKET, now + 5, 1'b1, 8'd255);
		now = now + 40;
		send(wcds_pkg::FUNC_TIMER, now, 1'b1, 8'd255);
		send(wcds_pkg::FUNC_PACKET, now - 6, 1'b1, 8'd1);
		send(wcds_pkg::FUNC_PACKET, now - 5, 1'b1, 8'd0);
		// zero dwell, then a run across the time wrap to the reshare
		send(wcds_pkg::FUNC_TIMER, now, 1'b0, 8'd0);
		for (int c = 3; c <= CH; c++) begin
			send(wcds_pkg::FUNC_PACKET, now + c, 1'b1, (c % 2) ? 8'd0 : 8'(c));
			now = now + 20 * c;
			send(wcds_pkg::FUNC_TIMER, now, 1'b1, 8'd0);
		end
		send(wcds_pkg::FUNC_PACKET, 32'hFFFF_FFFF, 1'b1, 8'd0);

		// random phases across register settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(wcds_pkg::REG_PERIOD,
						wcds_pkg::PERIOD_W'(wcds_pkg::PERIOD_RESET));
					write_reg(wcds_pkg::REG_MIN,
						wcds_pkg::PERIOD_W'(wcds_pkg::MIN_INTERVAL_RESET));
				end
				1: begin
					write_reg(wcds_pkg::REG_PERIOD, 20'd1);
					write_reg(wcds_pkg::REG_MIN, 20'd1);
				end
				2: begin
					write_reg(wcds_pkg::REG_PERIOD, 20'hFFFFF);
					write_reg(wcds_pkg::REG_MIN, 20'hFFFF);
				end
				default: begin
					write_reg(wcds_pkg::REG_PERIOD,
						wcds_pkg::PERIOD_W'($urandom_range(1, 20'hFFFFF)));
					write_reg(wcds_pkg::REG_MIN,
						wcds_pkg::PERIOD_W'($urandom_range(1, 300)));
				end
			endcase
			now = $urandom;
			for (int n = 0; n < 100; n++) dwell_round();
		end

		// drain
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
